>>> rtl/core/chtp_pkg.sv
// ----------------------------------------------------------------------------
// Clustered hash table probe package
// Shared types and constants for the probe front end, back end and top level.
// ----------------------------------------------------------------------------
package chtp_pkg;

	localparam int TAG_LSB    = 48;
	localparam int TAG_W      = 16;
	localparam int ENTRY_W    = 32;
	localparam int AGE_BIAS   = 259;
	localparam logic [7:0] GEN_MASK = 8'hFC;
	localparam int AGE_WEIGHT = 2;

	typedef enum logic {
		OP_PROBE = 1'b0,
		OP_WRITE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] tag;
		logic [1:0]       way;
		logic [7:0]       depth;
		logic [1:0]       bound;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

endpackage

>>> rtl/core/chtp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module chtp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/chtp_front.sv
// ----------------------------------------------------------------------------
// Probe front end
// Accepts items, splits the key into cluster and tag, and queues them.
// ----------------------------------------------------------------------------
module chtp_front #(
	parameter int CLUSTER_INDEX_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [63:0]                   lookup_key,
	input  logic [1:0]                    target_way,
	input  logic [7:0]                    write_depth,
	input  logic [1:0]                    write_bound,
	input  chtp_pkg::back_ctl_t           ctl,
	output chtp_pkg::head_t               head,
	output logic [CLUSTER_INDEX_BITS-1:0] head_cluster
);

	chtp_pkg::item_t               item_q [2];
	logic [CLUSTER_INDEX_BITS-1:0] clu_q  [2];
	logic                          wp_q;
	logic                          rp_q;
	logic [1:0]                    cnt_q;
	logic                          accept;
	logic                          pop;
	chtp_pkg::item_t               new_item;

	always_comb begin
		new_item.op    = chtp_pkg::op_t'(opcode);
		new_item.tag   = lookup_key[chtp_pkg::TAG_LSB +: chtp_pkg::TAG_W];
		new_item.way   = target_way;
		new_item.depth = write_depth;
		new_item.bound = write_bound;
	end

	assign in_stall = ctl.clearing || (cnt_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	assign pop      = ctl.pop && (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q[wp_q] <= new_item;
			clu_q[wp_q]  <= lookup_key[CLUSTER_INDEX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, accept} - {1'b0, pop};
		end
	end

	assign head.valid   = (cnt_q != 2'd0);
	assign head.item    = item_q[rp_q];
	assign head_cluster = clu_q[rp_q];

endmodule

>>> rtl/core/chtp_back.sv
// ----------------------------------------------------------------------------
// Probe back end
// Reads a cluster word, scans its ways, writes it back and registers the result.
// ----------------------------------------------------------------------------
module chtp_back #(
	parameter int WAYS_PER_CLUSTER   = 3,
	parameter int CLUSTER_INDEX_BITS = 16,
	parameter int PLY_UNIT           = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    gen_reg,
	input  chtp_pkg::head_t               head,
	input  logic [CLUSTER_INDEX_BITS-1:0] head_cluster,
	output chtp_pkg::back_ctl_t           ctl,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [1:0]                    chosen_way,
	output logic [15:0]                   cluster_index,
	output logic [7:0]                    entry_depth,
	output logic [1:0]                    entry_bound
);

	localparam int WAY_W   = $clog2(WAYS_PER_CLUSTER);
	localparam int LINE_W  = WAYS_PER_CLUSTER * chtp_pkg::ENTRY_W;
	localparam int DEPTH   = 1 << CLUSTER_INDEX_BITS;
	localparam int SCORE_W = $clog2(252 * chtp_pkg::AGE_WEIGHT * PLY_UNIT + 1) + 2;

	chtp_pkg::back_state_t         state_q, state_d;
	logic [CLUSTER_INDEX_BITS:0]   clr_q;
	chtp_pkg::item_t               item_q;
	logic [CLUSTER_INDEX_BITS-1:0] clu_q;

	logic                          ram_we;
	logic [CLUSTER_INDEX_BITS-1:0] ram_waddr;
	logic [LINE_W-1:0]             ram_wdata;
	logic                          ram_re;
	logic [LINE_W-1:0]             line;

	logic                          out_valid_q;
	logic                          hit_q;
	logic [1:0]                    way_q;
	logic [15:0]                   cluster_q;
	logic [7:0]                    depth_q;
	logic [1:0]                    bound_q;
	logic                          out_free;
	logic                          load_out;

	logic [7:0]                    gen;
	logic [chtp_pkg::ENTRY_W-1:0]  ent   [WAYS_PER_CLUSTER];
	logic signed [SCORE_W-1:0]     score [WAYS_PER_CLUSTER];
	logic                          found;
	logic                          match;
	logic [WAY_W-1:0]              hit_sel;
	logic [WAY_W-1:0]              vic_sel;
	logic [WAY_W-1:0]              sel;
	logic signed [SCORE_W-1:0]     best;
	logic [7:0]                    age;
	logic [chtp_pkg::ENTRY_W-1:0]  sel_ent;
	logic                          wr_ok;
	logic [LINE_W-1:0]             new_line;
	logic                          r_hit;
	logic [1:0]                    r_way;
	logic [7:0]                    r_depth;
	logic [1:0]                    r_bound;

	chtp_ram #(
		.WIDTH(LINE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_cluster),
		.rdata(line)
	);

	assign gen      = gen_reg & chtp_pkg::GEN_MASK;
	assign out_free = !out_valid_q || !out_stall;

	// Way scan: the first empty or matching way wins, otherwise the lowest score.
	always_comb begin
		found   = 1'b0;
		match   = 1'b0;
		hit_sel = '0;
		for (int w = 0; w < WAYS_PER_CLUSTER; w++) begin
			ent[w] = line[w*chtp_pkg::ENTRY_W +: chtp_pkg::ENTRY_W];
			age    = (8'(chtp_pkg::AGE_BIAS) + gen - ent[w][7:0]) & chtp_pkg::GEN_MASK;
			score[w] = $signed({{(SCORE_W-8){1'b0}}, ent[w][15:8]})
				- $signed(SCORE_W'(age * chtp_pkg::AGE_WEIGHT * PLY_UNIT));
			if (!found && (ent[w][31:16] == '0 || ent[w][31:16] == item_q.tag)) begin
				found   = 1'b1;
				match   = (ent[w][31:16] != '0);
				hit_sel = WAY_W'(w);
			end
		end
		best    = score[0];
		vic_sel = '0;
		for (int w = 1; w < WAYS_PER_CLUSTER; w++) begin
			if (best > score[w]) begin
				best    = score[w];
				vic_sel = WAY_W'(w);
			end
		end
		sel     = found ? hit_sel : vic_sel;
		sel_ent = ent[0];
		for (int w = 0; w < WAYS_PER_CLUSTER; w++) begin
			if (WAY_W'(w) == sel) begin
				sel_ent = ent[w];
			end
		end
		wr_ok    = (int'(item_q.way) < WAYS_PER_CLUSTER);
		new_line = line;
		for (int w = 0; w < WAYS_PER_CLUSTER; w++) begin
			if (item_q.op == chtp_pkg::OP_WRITE) begin
				if (wr_ok && int'(item_q.way) == w) begin
					new_line[w*chtp_pkg::ENTRY_W +: chtp_pkg::ENTRY_W] =
						{item_q.tag, item_q.depth, gen | {6'd0, item_q.bound}};
				end
			end else if (match && WAY_W'(w) == sel) begin
				new_line[w*chtp_pkg::ENTRY_W +: 8] = gen | {6'd0, ent[w][1:0]};
			end
		end
		if (item_q.op == chtp_pkg::OP_WRITE) begin
			r_hit   = 1'b0;
			r_way   = item_q.way;
			r_depth = wr_ok ? item_q.depth : 8'd0;
			r_bound = wr_ok ? item_q.bound : 2'd0;
		end else begin
			r_hit   = match;
			r_way   = 2'(sel);
			r_depth = sel_ent[15:8];
			r_bound = sel_ent[1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chtp_pkg::ST_CLEAR: begin
				if (clr_q[CLUSTER_INDEX_BITS]) begin
					state_d = chtp_pkg::ST_IDLE;
				end
			end
			chtp_pkg::ST_IDLE: begin
				if (head.valid) begin
					state_d = chtp_pkg::ST_EXEC;
				end
			end
			chtp_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = chtp_pkg::ST_IDLE;
				end
			end
			default: state_d = chtp_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = clu_q;
		ram_wdata    = new_line;
		ram_re       = 1'b0;
		ctl.pop      = 1'b0;
		ctl.clearing = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			chtp_pkg::ST_CLEAR: begin
				ctl.clearing = 1'b1;
				ram_we       = !clr_q[CLUSTER_INDEX_BITS];
				ram_waddr    = clr_q[CLUSTER_INDEX_BITS-1:0];
				ram_wdata    = '0;
			end
			chtp_pkg::ST_IDLE: begin
				ram_re  = head.valid;
				ctl.pop = head.valid;
			end
			chtp_pkg::ST_EXEC: begin
				ram_we   = out_free;
				load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= chtp_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == chtp_pkg::ST_CLEAR && !clr_q[CLUSTER_INDEX_BITS]) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q <= head.item;
			clu_q  <= head_cluster;
		end
		if (load_out) begin
			hit_q     <= r_hit;
			way_q     <= r_way;
			cluster_q <= 16'(clu_q);
			depth_q   <= r_depth;
			bound_q   <= r_bound;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign chosen_way    = way_q;
	assign cluster_index = cluster_q;
	assign entry_depth   = depth_q;
	assign entry_bound   = bound_q;

endmodule

>>> rtl/core/clustered_hash_table_probe.sv
// ----------------------------------------------------------------------------
// Clustered hash table probe
// Set-associative entry table with tag lookup and depth/age victim choice.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall with opcode, lookup_key, target_way,
// write_depth and write_bound; each item yields one result item on
// out_valid/out_stall carrying hit, chosen_way, cluster_index, entry_depth and
// entry_bound. Items enter a two-deep queue; the back end then reads the whole
// cluster as one memory word, scans its ways and writes the word back.
// The back end reads the cluster word in ST_IDLE and evaluates and writes it
// back in ST_EXEC, a read-modify-write of the cluster memory; it takes no new
// item before the last is through. An accepted item passes the queue, ST_IDLE
// and ST_EXEC before the registered result raises out_valid. After reset the
// block clears all 2**CLUSTER_INDEX_BITS table words and holds in_stall high
// meanwhile; search_generation resets to zero and is written through cfg_wr_en
// while no item is in flight: the user must keep to this, the block does not
// enforce it. While out_stall is high the result stays registered and the back
// end waits; the queue keeps taking items until it holds two.
// ----------------------------------------------------------------------------
module clustered_hash_table_probe #(
	parameter int WAYS_PER_CLUSTER   = 3,
	parameter int CLUSTER_INDEX_BITS = 16,
	parameter int PLY_UNIT           = 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [63:0] lookup_key,
	input  logic [1:0]  target_way,
	input  logic [7:0]  write_depth,
	input  logic [1:0]  write_bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [1:0]  chosen_way,
	output logic [15:0] cluster_index,
	output logic [7:0]  entry_depth,
	output logic [1:0]  entry_bound
);

	logic [7:0]                    search_generation_q;
	chtp_pkg::back_ctl_t           ctl;
	chtp_pkg::head_t               head;
	logic [CLUSTER_INDEX_BITS-1:0] head_cluster;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_generation_q <= 8'd0;
		end else if (cfg_wr_en) begin
			search_generation_q <= cfg_wr_data;
		end
	end

	chtp_front #(
		.CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.lookup_key  (lookup_key),
		.target_way  (target_way),
		.write_depth (write_depth),
		.write_bound (write_bound),
		.ctl         (ctl),
		.head        (head),
		.head_cluster(head_cluster)
	);

	chtp_back #(
		.WAYS_PER_CLUSTER  (WAYS_PER_CLUSTER),
		.CLUSTER_INDEX_BITS(CLUSTER_INDEX_BITS),
		.PLY_UNIT          (PLY_UNIT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.gen_reg      (search_generation_q),
		.head         (head),
		.head_cluster (head_cluster),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.chosen_way   (chosen_way),
		.cluster_index(cluster_index),
		.entry_depth  (entry_depth),
		.entry_bound  (entry_bound)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clustered hash table probe testbench
// Drives probe and write items with random bursts and output stalls, predicts
// each result with a behavioral copy of the cluster table, and compares.
// ----------------------------------------------------------------------------
module tb;

	localparam int WAYS      = 3;
	localparam int IDX_BITS  = 16;
	localparam int PLY       = 1;
	localparam longint LIMIT = 64'd3000000;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way;
		logic [15:0] cluster;
		logic [7:0]  depth;
		logic [1:0]  bound;
	} probe_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [63:0] lookup_key;
	logic [1:0]  target_way;
	logic [7:0]  write_depth;
	logic [1:0]  write_bound;
	logic        out_valid;
	logic        out_stall;
	logic        hit;
	logic [1:0]  chosen_way;
	logic [15:0] cluster_index;
	logic [7:0]  entry_depth;
	logic [1:0]  entry_bound;

	clustered_hash_table_probe #(
		.WAYS_PER_CLUSTER(WAYS),
		.CLUSTER_INDEX_BITS(IDX_BITS),
		.PLY_UNIT(PLY)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .lookup_key(lookup_key), .target_way(target_way),
		.write_depth(write_depth), .write_bound(write_bound),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .chosen_way(chosen_way), .cluster_index(cluster_index),
		.entry_depth(entry_depth), .entry_bound(entry_bound)
	);

	// Sparse model of the table: missing entries read as zero.
	logic [31:0]   table_model [int];
	logic [7:0]    model_gen;
	probe_result_t expected_results [$];
	int            mismatch_count;
	longint        cycle_count;
	bit            hold_off_req;
	bit            stall_random;
	logic [63:0]   recent_keys [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic [31:0] read_entry(int addr);
		if (table_model.exists(addr))
			return table_model[addr];
		return 32'd0;
	endfunction

	function automatic int entry_score(logic [31:0] e, logic [7:0] gen);
		logic [8:0] age;
		age = 9'((chtp_pkg::AGE_BIAS + int'(gen) - int'(e[7:0]))
			& int'(chtp_pkg::GEN_MASK));
		return int'(e[15:8]) - int'(age) * chtp_pkg::AGE_WEIGHT * PLY;
	endfunction

	// Updates the table model and returns the result one item produces.
	function automatic probe_result_t predict_lookup(chtp_pkg::op_t op,
			logic [63:0] key, logic [1:0] way_in, logic [7:0] wdepth,
			logic [1:0] wbound);
		probe_result_t r;
		logic [7:0]  gen;
		logic [15:0] tag;
		int          base;
		logic [31:0] e;
		bit          done;
		int          best;
		int          s;
		gen = model_gen & chtp_pkg::GEN_MASK;
		tag = key[63:chtp_pkg::TAG_LSB];
		r = '0;
		r.cluster = key[IDX_BITS-1:0];
		base = int'(r.cluster) * WAYS;
		if (op == chtp_pkg::OP_WRITE) begin
			r.way = way_in;
			if (way_in < WAYS) begin
				table_model[base + way_in] = {tag, wdepth, gen | {6'd0, wbound}};
				r.depth = wdepth;
				r.bound = wbound;
			end
			return r;
		end
		done = 0;
		for (int i = 0; i < WAYS && !done; i++) begin
			e = read_entry(base + i);
			if (e[31:16] == 16'd0) begin
				r.way = 2'(i);
				done = 1;
			end else if (e[31:16] == tag) begin
				// Refresh the generation but keep the bound bits.
				table_model[base + i] = {e[31:8], gen | {6'd0, e[1:0]}};
				r.hit = 1'b1;
				r.way = 2'(i);
				done = 1;
			end
		end
		if (!done) begin
			best = entry_score(read_entry(base), gen);
			r.way = 2'd0;
			for (int i = 1; i < WAYS; i++) begin
				s = entry_score(read_entry(base + i), gen);
				if (best > s) begin
					best = s;
					r.way = 2'(i);
				end
			end
		end
		e = read_entry(base + r.way);
		r.depth = e[15:8];
		r.bound = e[1:0];
		return r;
	endfunction

	// Leaves in_valid high on return so that the next item can follow directly.
	task automatic send_item(chtp_pkg::op_t op, logic [63:0] key, logic [1:0] way_in,
			logic [7:0] wdepth, logic [1:0] wbound);
		expected_results.push_back(predict_lookup(op, key, way_in, wdepth, wbound));
		in_valid    <= 1'b1;
		opcode      <= op;
		lookup_key  <= key;
		target_way  <= way_in;
		write_depth <= wdepth;
		write_bound <= wbound;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic random_gap();
		int gap;
		if ($urandom_range(0, 3) != 0)
			return;
		gap = $urandom_range(1, 6);
		in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_gen_reg(logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_gen = value;
	endtask

	// Keys drawn from a small pool of clusters so that clusters fill and evict.
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		if (recent_keys.size() != 0 && $urandom_range(0, 2) == 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		k = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0)
			k[IDX_BITS-1:0] = 16'($urandom_range(0, 7)) * 16'd4099;
		if ($urandom_range(0, 3) == 0)
			k[63:48] = 16'($urandom_range(0, 5));
		recent_keys.push_back(k);
		if (recent_keys.size() > 40)
			void'(recent_keys.pop_front());
		return k;
	endfunction

	task automatic test_directed();
		logic [63:0] k;
		k = 64'hFFFF_0000_0000_FFFF;
		send_item(chtp_pkg::OP_PROBE, k, 2'd0, 8'd0, 2'd0);
		send_item(chtp_pkg::OP_WRITE, k, 2'd0, 8'hFF, 2'd3);
		send_item(chtp_pkg::OP_PROBE, k, 2'd1, 8'd0, 2'd0);
		send_item(chtp_pkg::OP_WRITE, k, 2'd3, 8'h55, 2'd1);
		send_item(chtp_pkg::OP_WRITE, {16'h0001, 48'h0000_0000_FFFF}, 2'd1, 8'h00, 2'd0);
		send_item(chtp_pkg::OP_WRITE, {16'h0002, 48'h0000_0000_FFFF}, 2'd2, 8'h80, 2'd2);
		send_item(chtp_pkg::OP_PROBE, {16'h1234, 48'h0000_0000_FFFF}, 2'd0, 8'd0, 2'd0);
		send_item(chtp_pkg::OP_WRITE, {16'h0000, 48'h0000_0000_0000}, 2'd0, 8'h12, 2'd1);
		send_item(chtp_pkg::OP_PROBE, 64'd0, 2'd0, 8'd0, 2'd0);
		send_item(chtp_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_0000, 2'd0, 8'd0, 2'd0);
		send_item(chtp_pkg::OP_PROBE, {16'h0002, 48'h0000_0000_FFFF}, 2'd0, 8'd0, 2'd0);
		// Ties in score go to the earlier way.
		send_item(chtp_pkg::OP_WRITE, 64'hAAAA_0000_0000_0005, 2'd0, 8'd10, 2'd0);
		send_item(chtp_pkg::OP_WRITE, 64'hBBBB_0000_0000_0005, 2'd1, 8'd10, 2'd3);
		send_item(chtp_pkg::OP_WRITE, 64'hCCCC_0000_0000_0005, 2'd2, 8'd10, 2'd1);
		send_item(chtp_pkg::OP_PROBE, 64'hDDDD_5555_5555_0005, 2'd0, 8'd0, 2'd0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 2) == 0)
				send_item(chtp_pkg::OP_WRITE, pick_key(), 2'($urandom_range(0, 3)),
					8'($urandom), 2'($urandom));
			else
				send_item(chtp_pkg::OP_PROBE, pick_key(), 2'($urandom),
					8'($urandom), 2'($urandom));
			random_gap();
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_off_req = 1;
		for (int n = 0; n < 20; n++)
			send_item(chtp_pkg::op_t'($urandom_range(0, 1)), pick_key(),
				2'($urandom_range(0, 3)), 8'($urandom), 2'($urandom));
		wait_drained();
	endtask

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				out_stall <= 1'b1;
				repeat (60) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_random) begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		probe_result_t exp_r;
		probe_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {hit, chosen_way, cluster_index, entry_depth, entry_bound};
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: %h", $realtime, got);
				mismatch_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (got.hit !== exp_r.hit || got.way !== exp_r.way
						|| got.cluster !== exp_r.cluster || got.depth !== exp_r.depth
						|| got.bound !== exp_r.bound) begin
					$display("%0t: expected hit=%0d way=%0d cluster=%h depth=%0d bound=%0d",
						$realtime, exp_r.hit, exp_r.way, exp_r.cluster, exp_r.depth,
						exp_r.bound);
					$display("%0t: actual   hit=%0d way=%0d cluster=%h depth=%0d bound=%0d",
						$realtime, got.hit, got.way, got.cluster, got.depth, got.bound);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count    = 0;
		hold_off_req   = 0;
		stall_random   = 0;
		model_gen      = 8'd0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 8'd0;
		in_valid    = 1'b0;
		opcode      = chtp_pkg::OP_PROBE;
		lookup_key  = 64'd0;
		target_way  = 2'd0;
		write_depth = 8'd0;
		write_bound = 2'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_random = 1;
		write_gen_reg(8'd4);
		test_random(150);
		write_gen_reg(8'd255);
		test_random(150);
		test_backpressure();
		write_gen_reg(8'd0);
		test_random(150);
		write_gen_reg(8'd130);
		test_random(150);
		wait_drained();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> clustered_hash_table_probe.f
rtl/core/chtp_pkg.sv
rtl/core/chtp_ram.sv
rtl/core/chtp_front.sv
rtl/core/chtp_back.sv
rtl/core/clustered_hash_table_probe.sv
tb/tb.sv
